/* rtl/core/convex_hull_support_argmax_unit_macros.svh */
//------------------------------------------------------------------------------
// convex_hull_support_argmax_unit_macros
// Assertion macros for the hull support unit.
//------------------------------------------------------------------------------
`ifndef CONVEX_HULL_SUPPORT_ARGMAX_UNIT_MACROS_SVH
`define CONVEX_HULL_SUPPORT_ARGMAX_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CHS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/chsa_pkg.sv */
//------------------------------------------------------------------------------
// chsa_pkg
// Types, codes and binary32 arithmetic helpers for the hull support unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chsa_pkg;

  localparam int unsigned FpW = 32;
  localparam logic [FpW-1:0] FpNegInf = 32'hFF80_0000;
  localparam logic [FpW-1:0] FpQNan   = 32'h7FC0_0000;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD1,
    ST_ADD2,
    ST_CMP,
    ST_OUT
  } state_e;

  // Shared unit operation select.
  typedef enum logic {
    FU_MUL = 1'b0,
    FU_ADD = 1'b1
  } fu_op_e;

  typedef struct packed {
    logic       start;
    fu_op_e     op;
  } fu_ctrl_t;

  function automatic logic fp_is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // a > b in IEEE order; false on NaN.
  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic a_zero;
    logic b_zero;
    logic res;
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (fp_is_nan(a) || fp_is_nan(b) || (a_zero && b_zero)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = !a[31];
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/chsa_fpu.sv */
//------------------------------------------------------------------------------
// chsa_fpu
// Shared binary32 multiply / add unit, round to nearest even. Two stages:
// stage one aligns or multiplies, stage two normalizes and rounds.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chsa_fpu
  import chsa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire fu_ctrl_t    ctrl_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [31:0]      res_o
);

  // Stage 1 register: special result or raw sign/exponent/mantissa.
  logic        v1_q;
  logic        spec_q;
  logic [31:0] spec_res_q;
  logic        sgn_q;
  logic signed [10:0] exp_q;   // exponent of bit 49 of mant_q
  logic [49:0] mant_q;         // raw value, sticky folded into bit 0
  logic [31:0] res_q;
  logic        done_q;

  // ---------------- stage 1 ----------------
  logic        s1_spec;
  logic [31:0] s1_spec_res;
  logic        s1_sgn;
  logic signed [10:0] s1_exp;
  logic [49:0] s1_mant;

  always_comb begin
    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        na, nb, ia, ib, za, zb;
    logic signed [10:0] xa, xb;
    logic [47:0] prod;
    logic [49:0] al, bl, sm;
    logic signed [10:0] xd;
    logic [5:0]  sh;
    logic [49:0] bsh;
    logic        stk;
    logic [49:0] lost;
    sa = a_i[31]; sb = b_i[31];
    ea = a_i[30:23]; eb = b_i[30:23];
    na = fp_is_nan(a_i); nb = fp_is_nan(b_i);
    ia = (ea == 8'hFF) && !na; ib = (eb == 8'hFF) && !nb;
    za = (a_i[30:0] == 31'd0); zb = (b_i[30:0] == 31'd0);
    ma = {(ea != 8'd0), a_i[22:0]};
    mb = {(eb != 8'd0), b_i[22:0]};
    xa = (ea == 8'd0) ? 11'sd1 : $signed({3'b000, ea});
    xb = (eb == 8'd0) ? 11'sd1 : $signed({3'b000, eb});
    s1_spec = 1'b0; s1_spec_res = FpQNan;
    s1_sgn = 1'b0; s1_exp = '0; s1_mant = '0;
    prod = '0; al = '0; bl = '0; sm = '0; xd = '0; sh = '0; bsh = '0;
    stk = 1'b0; lost = '0;
    if (ctrl_i.op == FU_MUL) begin
      s1_sgn = sa ^ sb;
      if (na || nb || (ia && zb) || (ib && za)) begin
        s1_spec = 1'b1; s1_spec_res = FpQNan;
      end else if (ia || ib) begin
        s1_spec = 1'b1; s1_spec_res = {sa ^ sb, 8'hFF, 23'd0};
      end else if (za || zb) begin
        s1_spec = 1'b1; s1_spec_res = {sa ^ sb, 31'd0};
      end else begin
        prod = ma * mb;                      // value = prod * 2^(xa+xb-127-46-127)
        s1_mant = {prod, 2'b00};
        // bit 49 weight: 2^(xa+xb-254+1) relative to unbiased; keep biased form
        s1_exp = xa + xb - 11'sd126;
      end
    end else begin
      if (na || nb || (ia && ib && (sa != sb))) begin
        s1_spec = 1'b1; s1_spec_res = FpQNan;
      end else if (ia) begin
        s1_spec = 1'b1; s1_spec_res = a_i;
      end else if (ib) begin
        s1_spec = 1'b1; s1_spec_res = b_i;
      end else if (za && zb) begin
        s1_spec = 1'b1; s1_spec_res = {sa & sb, 31'd0};
      end else begin
        // operands placed with hidden bit at 48, guard room below
        al = {1'b0, ma, 25'd0};
        bl = {1'b0, mb, 25'd0};
        if ((xa < xb) || ((xa == xb) && (ma < mb))) begin
          {al, bl} = {bl, al};
          {sa, sb} = {sb, sa};
          xd = xb - xa;
          s1_exp = xb + 11'sd1;
        end else begin
          xd = xa - xb;
          s1_exp = xa + 11'sd1;
        end
        sh = (xd > 11'sd49) ? 6'd49 : xd[5:0];
        bsh = bl >> sh;
        lost = bl & ~({50{1'b1}} << sh);
        stk = (lost != '0);
        bsh[0] = bsh[0] | stk;
        sm = (sa == sb) ? (al + bsh) : (al - bsh);
        s1_sgn = sa;
        s1_mant = sm;
        if (sm == '0) begin
          s1_spec = 1'b1; s1_spec_res = 32'd0;   // exact cancel, RNE gives +0
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    spec_q     <= s1_spec;
    spec_res_q <= s1_spec_res;
    sgn_q      <= s1_sgn;
    exp_q      <= s1_exp;
    mant_q     <= s1_mant;
  end

  // ---------------- stage 2: normalize and round ----------------
  // value = mant_q * 2^(exp_q - 127 - 49 + ...): bit 49 has biased exponent exp_q.
  logic [31:0] s2_res;
  always_comb begin
    logic [5:0]  lz;
    logic        fnd;
    logic signed [11:0] e;
    logic [49:0] m;
    logic [5:0]  rs;
    logic [49:0] lost;
    logic [23:0] keep;
    logic        g, st, inc;
    logic [24:0] rnd;
    lz = '0; fnd = 1'b0; m = '0; rs = '0; lost = '0; keep = '0;
    g = 1'b0; st = 1'b0; inc = 1'b0; rnd = '0; e = '0;
    for (int i = 49; i >= 0; i--) begin
      if (!fnd && mant_q[i]) begin
        fnd = 1'b1;
        lz = 6'(49 - i);
      end
    end
    e = $signed({exp_q[10], exp_q}) - $signed({6'd0, lz});
    m = mant_q << lz;                        // leading one at bit 49
    if (e < 12'sd1) begin                    // subnormal: shift right
      rs = ((12'sd1 - e) > 12'sd50) ? 6'd50 : 6'(12'sd1 - e);
      lost = m & ~({50{1'b1}} << rs);
      m = m >> rs;
      m[0] = m[0] | (lost != '0);
      e = 12'sd0;
    end
    keep = m[49:26];
    g    = m[25];
    st   = (m[24:0] != '0);
    inc  = g && (st || keep[0]);
    rnd  = {1'b0, keep} + {24'd0, inc};
    if (rnd[24]) begin
      e = e + 12'sd1;
      rnd = {1'b0, 1'b1, 23'd0};
    end else if ((e == 12'sd0) && rnd[23]) begin
      e = 12'sd1;                             // subnormal rounded up to normal
    end
    if (e >= 12'sd255) begin
      s2_res = {sgn_q, 8'hFF, 23'd0};
    end else begin
      s2_res = {sgn_q, e[7:0], rnd[22:0]};
    end
    if (spec_q) begin
      s2_res = spec_res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      res_q <= s2_res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* rtl/core/convex_hull_support_argmax_unit.sv */
//------------------------------------------------------------------------------
// convex_hull_support_argmax_unit
// Support mapping over a stored hull: argmax of the binary32 dot product.
//------------------------------------------------------------------------------
// Channel   Dir  Fields (tdata low bit first)                       tuser
// s_axis    in   vertex_index[4:0] vx vy vz dx dy dz (197 -> 200)   operation
// m_axis    out  support_index x y z projection (133 -> 136 bits)   -
// cfg       in   vertex_count[5:0], write enable                    -
//
// A store is written on accept. A query holds the input until its result
// is taken, scanning N vertices: per vertex 3 multiplies and 2 adds, each
// through issue, FPU stage one and FPU stage two, then a compare; after the
// scan, ST_MUL sees its end and ST_OUT presents the result, which m_axis
// stalls hold.
// Reset clears control state only; the vertex table is undefined until
// written. s_axis_tready is low from query accept until the result leaves.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module convex_hull_support_argmax_unit
  import chsa_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [5:0]   cfg_wdata_i,      // vertex_count
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // vertex_index[4:0], vertex_x[36:5], vertex_y[68:37], vertex_z[100:69],
  // dir_x[132:101], dir_y[164:133], dir_z[196:165], zero pad to 200
  input  wire logic [199:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,     // operation
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // support_index[4:0], x[36:5], y[68:37], z[100:69], projection[132:101],
  // zero pad to 136
  output logic [135:0]      m_axis_tdata
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  // vertex table
  logic [95:0] vmem [MAX_VERTICES];
  logic [95:0] rd_q;

  state_e state_q, state_d;
  logic [5:0]    count_q;
  logic [CW-1:0] lim_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [1:0]    sub_q, sub_d;     // which multiply
  logic          wait_q, wait_d;   // FPU op in flight
  logic [31:0] dx_q, dy_q, dz_q;
  logic [31:0] acc_q, pz_q;
  logic [31:0] best_q;
  logic        found_q;
  logic [AW-1:0] bidx_q;
  logic          out_v_q;

  fu_ctrl_t   fu_ctrl;
  logic [31:0] fu_a, fu_b, fu_res;
  logic        fu_done;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  logic [4:0] st_idx;
  assign st_idx = s_axis_tdata[4:0];

  always_ff @(posedge clk_i) begin
    if (s_acc && (s_axis_tuser == OP_STORE) && (32'(st_idx) < MAX_VERTICES)) begin
      vmem[AW'(st_idx)] <= s_axis_tdata[100:5];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= vmem[idx_d[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 6'd1;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sub_d   = sub_q;
    wait_d  = wait_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (s_acc && (s_axis_tuser == OP_QUERY)) begin
          state_d = ST_MUL; sub_d = 2'd0; wait_d = 1'b0;
        end
      end
      ST_MUL: begin
        if (idx_q >= lim_q) begin
          state_d = ST_OUT;
          idx_d   = CW'(bidx_q);
        end else if (!wait_q) begin
          wait_d = 1'b1;
        end else if (fu_done) begin
          wait_d = 1'b0;
          if (sub_q == 2'd2) begin
            sub_d = 2'd0; state_d = ST_ADD1;
          end else begin
            sub_d = sub_q + 2'd1;
          end
        end
      end
      ST_ADD1, ST_ADD2: begin
        if (!wait_q) begin
          wait_d = 1'b1;
        end else if (fu_done) begin
          wait_d  = 1'b0;
          state_d = (state_q == ST_ADD1) ? ST_ADD2 : ST_CMP;
        end
      end
      ST_CMP: begin
        idx_d   = idx_q + CW'(1);
        state_d = ST_MUL;
      end
      ST_OUT: begin
        idx_d = CW'(bidx_q);
        if (out_v_q && m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FPU drive
  always_comb begin
    fu_ctrl.start = 1'b0;
    fu_ctrl.op    = FU_MUL;
    fu_a = '0;
    fu_b = '0;
    unique case (state_q)
      ST_MUL: begin
        fu_ctrl.start = (idx_q < lim_q) && !wait_q;
        unique case (sub_q)
          2'd0:    begin fu_a = rd_q[31:0];  fu_b = dx_q; end
          2'd1:    begin fu_a = rd_q[63:32]; fu_b = dy_q; end
          default: begin fu_a = rd_q[95:64]; fu_b = dz_q; end
        endcase
      end
      ST_ADD1: begin
        fu_ctrl.start = !wait_q; fu_ctrl.op = FU_ADD;
        fu_a = acc_q; fu_b = pz_q;   // px + py
      end
      ST_ADD2: begin
        fu_ctrl.start = !wait_q; fu_ctrl.op = FU_ADD;
        fu_a = acc_q; fu_b = pz_q;   // (px + py) + pz
      end
      default: ;
    endcase
  end

  chsa_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fu_ctrl),
    .a_i    (fu_a),
    .b_i    (fu_b),
    .done_o (fu_done),
    .res_o  (fu_res)
  );

  // products: px -> acc, py -> pz, pz held in pzz_q until ST_ADD1 moves it to pz_q
  logic [31:0] pzz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      sub_q   <= '0;
      wait_q  <= 1'b0;
      found_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      sub_q   <= sub_d;
      wait_q  <= wait_d;
      if (state_q == ST_IDLE) begin
        found_q <= 1'b0;
      end else if ((state_q == ST_CMP) && (!found_q ? fp_gt(acc_q, FpNegInf)
                                                    : fp_gt(acc_q, best_q))) begin
        found_q <= 1'b1;
      end
      if ((state_q == ST_MUL) && (state_d == ST_OUT)) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && (s_axis_tuser == OP_QUERY)) begin
      dx_q   <= s_axis_tdata[132:101];
      dy_q   <= s_axis_tdata[164:133];
      dz_q   <= s_axis_tdata[196:165];
      best_q <= FpNegInf;
      bidx_q <= '0;
      lim_q  <= (32'(count_q) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(count_q);
    end
    if (fu_done) begin
      unique case (state_q)
        ST_MUL: begin
          unique case (sub_q)
            2'd0:    acc_q <= fu_res;
            2'd1:    pz_q  <= fu_res;
            default: pzz_q <= fu_res;
          endcase
        end
        ST_ADD1: begin
          acc_q <= fu_res;
          pz_q  <= pzz_q;
        end
        default: acc_q <= fu_res;
      endcase
    end
    if ((state_q == ST_CMP) && (!found_q ? fp_gt(acc_q, FpNegInf)
                                         : fp_gt(acc_q, best_q))) begin
      best_q <= acc_q;
      bidx_q <= idx_q[AW-1:0];
    end
  end

  // the table read follows idx_d, so in ST_OUT rd_q holds the winner
  logic [95:0] out_vtx;
  assign out_vtx = rd_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q && (state_q == ST_OUT);
  assign m_axis_tdata  = {3'd0, best_q, out_vtx, 5'(bidx_q)};

endmodule

`default_nettype wire

/* rtl/core/chsa_checker.sv */
//------------------------------------------------------------------------------
// chsa_checker
// Port-level checks for the hull support unit, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "convex_hull_support_argmax_unit_macros.svh"

module chsa_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [135:0] m_axis_tdata
);

  `CHS_ASSERT_IMP(a_no_accept_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `CHS_ASSERT_NXT(a_store_no_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !m_axis_tvalid, "store produced result")
  `CHS_ASSERT_NXT(a_query_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "ready after query accept")
  `CHS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")

endmodule

bind convex_hull_support_argmax_unit chsa_checker u_chsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/convex_hull_support_argmax_unit_test.sv */
//------------------------------------------------------------------------------
// convex_hull_support_argmax_unit_test
// Drives stores and support queries into the hull unit and checks each result
// against a bit-exact binary32 predictor in the bench or a typed-in expectation.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module convex_hull_support_argmax_unit_test;
  import chsa_pkg::*;

  localparam int unsigned NumVerts   = 32;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 84;
  localparam int unsigned CycleLimit = 3_000_000;

  // one support result
  typedef struct {
    logic [4:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] proj;
  } support_t;

  // one directed stimulus row; the expected index and projection are typed in
  // only where has_exp is set
  typedef struct {
    op_e         op;
    logic [4:0]  idx;
    logic [31:0] vx, vy, vz;
    logic [31:0] dx, dy, dz;
    logic        has_exp;
    logic [4:0]  exp_idx;
    logic [31:0] exp_proj;
  } stim_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [5:0]    cfg_wdata_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [199:0]  s_axis_tdata = '0;
  logic          s_axis_tuser = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;

  // bench copy of the hull table and the count register
  logic [31:0]   hull_x [NumVerts];
  logic [31:0]   hull_y [NumVerts];
  logic [31:0]   hull_z [NumVerts];
  logic          hull_written [NumVerts];
  logic [5:0]    hull_count;

  support_t      pending_supports[$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  logic          quiet = 1'b0;

  convex_hull_support_argmax_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  //----------------------------------------------------------------------------
  // binary32 arithmetic, round to nearest even, subnormals kept
  //----------------------------------------------------------------------------

  // value = sig * 2^e; rounds and packs into binary32
  function automatic logic [31:0] fp_round_pack(input logic s, input int e,
                                                input logic [79:0] sig);
    int          lead;
    int          sh;
    int          biased;
    logic [79:0] kept;
    logic [79:0] mask;
    logic        guard;
    logic        sticky;
    logic [31:0] r;
    if (sig == '0) begin
      return {s, 31'd0};
    end
    lead = 0;
    for (int i = 0; i < 80; i++) begin
      if (sig[i]) begin
        lead = i;
      end
    end
    sh = lead - 23;
    if (sh < -149 - e) begin
      sh = -149 - e;           // subnormal: fixed scale 2^-149
    end
    if (sh <= 0) begin
      kept = sig << (-sh);
      guard = 1'b0;
      sticky = 1'b0;
    end else begin
      kept = (sh >= 80) ? '0 : (sig >> sh);
      guard = (sh - 1 < 80) ? sig[sh-1] : 1'b0;
      mask = (sh - 1 >= 80) ? '1 : ((80'd1 << (sh - 1)) - 80'd1);
      sticky = |(sig & mask);
    end
    if (guard && (sticky || kept[0])) begin
      kept = kept + 80'd1;
    end
    if (kept == (80'd1 << 24)) begin
      kept = kept >> 1;
      sh = sh + 1;
    end
    if (kept[23]) begin
      biased = e + sh + 150;
      if (biased >= 255) begin
        r = {s, 8'hFF, 23'd0};
      end else begin
        r = {s, biased[7:0], kept[22:0]};
      end
    end else begin
      r = {s, 8'd0, kept[22:0]};
    end
    return r;
  endfunction

  function automatic logic fp_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != '0);
  endfunction

  function automatic logic fp_inf(input logic [31:0] a);
    return (a[30:0] == 31'h7F80_0000);
  endfunction

  function automatic logic [23:0] fp_sig(input logic [31:0] a);
    return {(a[30:23] != 8'd0), a[22:0]};
  endfunction

  function automatic int fp_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [79:0] prod;
    s = a[31] ^ b[31];
    if (fp_nan(a) || fp_nan(b)) begin
      return FpQNan;
    end
    if (fp_inf(a) || fp_inf(b)) begin
      if (a[30:0] == '0 || b[30:0] == '0) begin
        return FpQNan;
      end
      return {s, 31'h7F80_0000};
    end
    if (a[30:0] == '0 || b[30:0] == '0) begin
      return {s, 31'd0};
    end
    prod = 80'(fp_sig(a)) * 80'(fp_sig(b));
    return fp_round_pack(s, fp_exp(a) + fp_exp(b) - 300, prod);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] lit;
    int          d;
    int          k;
    int          rs;
    logic [79:0] big_sig;
    logic [79:0] lit_sig;
    logic [31:0] lit_raw;
    logic [79:0] total;
    if (fp_nan(a) || fp_nan(b)) begin
      return FpQNan;
    end
    if (fp_inf(a) && fp_inf(b)) begin
      return (a[31] == b[31]) ? a : FpQNan;
    end
    if (fp_inf(a)) begin
      return a;
    end
    if (fp_inf(b)) begin
      return b;
    end
    if (a[30:0] == '0 && b[30:0] == '0) begin
      return {a[31] & b[31], 31'd0};
    end
    if (a[30:0] == '0) begin
      return b;
    end
    if (b[30:0] == '0) begin
      return a;
    end
    if (a[30:0] >= b[30:0]) begin
      big = a;
      lit = b;
    end else begin
      big = b;
      lit = a;
    end
    d = fp_exp(big) - fp_exp(lit);
    k = (d > 40) ? 40 : d;
    rs = d - k;
    big_sig = 80'(fp_sig(big)) << k;
    // far-off addend only matters as a sticky bit under the wide guard field
    lit_raw = 32'(fp_sig(lit));
    if (rs >= 32) begin
      lit_sig = 80'd1;
    end else begin
      lit_sig = 80'(lit_raw >> rs);
      if ((lit_raw & ((32'd1 << rs) - 32'd1)) != '0) begin
        lit_sig[0] = 1'b1;
      end
    end
    total = (big[31] == lit[31]) ? big_sig + lit_sig : big_sig - lit_sig;
    if (total == '0) begin
      return 32'd0;            // exact cancellation gives +0
    end
    return fp_round_pack(big[31], fp_exp(big) - 150 - k, total);
  endfunction

  // strict IEEE greater-than; false on NaN and on two zeros
  function automatic logic fp_greater(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if (fp_nan(a) || fp_nan(b) || (a[30:0] == '0 && b[30:0] == '0)) begin
      return 1'b0;
    end
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka > kb;
  endfunction

  // argmax of the projection over the active part of the hull
  function automatic support_t hull_support_predict(input logic [31:0] dx,
                                                    input logic [31:0] dy,
                                                    input logic [31:0] dz);
    support_t    res;
    int          n;
    logic [31:0] p;
    logic [31:0] best;
    n = (hull_count > NumVerts) ? NumVerts : int'(hull_count);
    best = FpNegInf;
    res.idx = '0;
    for (int i = 0; i < n; i++) begin
      p = fp_add(fp_add(fp_mul(hull_x[i], dx), fp_mul(hull_y[i], dy)),
                 fp_mul(hull_z[i], dz));
      if (fp_greater(p, best)) begin
        best = p;
        res.idx = 5'(i);
      end
    end
    res.x = hull_x[res.idx];
    res.y = hull_y[res.idx];
    res.z = hull_z[res.idx];
    res.proj = best;
    return res;
  endfunction

  //----------------------------------------------------------------------------
  // stimulus helpers
  //----------------------------------------------------------------------------

  // binary32 word: specials, raw bits, subnormals, or moderate values that rarely overflow
  function automatic logic [31:0] pick_float();
    logic [31:0] specials [10];
    logic [31:0] w;
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F7F_FFFF, 32'h3F80_0000};
    case ($urandom_range(0, 11))
      0:       w = specials[$urandom_range(0, 9)];
      1:       w = $urandom;
      2:       w = {1'($urandom), 8'd0, 23'($urandom)};            // subnormal
      default: w = {1'($urandom), 8'($urandom_range(112, 140)), 23'($urandom)};
    endcase
    return w;
  endfunction

  // accept one item, then record what it should produce
  task automatic push_item(input op_e op, input logic [4:0] idx,
                           input logic [31:0] vx, input logic [31:0] vy,
                           input logic [31:0] vz, input logic [31:0] dx,
                           input logic [31:0] dy, input logic [31:0] dz,
                           input logic has_exp, input logic [4:0] exp_idx,
                           input logic [31:0] exp_proj);
    support_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, dz, dy, dx, vz, vy, vx, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_STORE) begin
      hull_x[idx] = vx;
      hull_y[idx] = vy;
      hull_z[idx] = vz;
      hull_written[idx] = 1'b1;
    end else begin
      res = hull_support_predict(dx, dy, dz);
      if (has_exp) begin
        res.idx = exp_idx;
        res.x = hull_x[exp_idx];
        res.y = hull_y[exp_idx];
        res.z = hull_z[exp_idx];
        res.proj = exp_proj;
      end
      pending_supports.push_back(res);
    end
  endtask

  // stop sending and let every outstanding query come back
  task automatic drain_queries();
    s_axis_tvalid <= 1'b0;
    while (pending_supports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);  // let a trailing store complete
  endtask

  task automatic write_count(input logic [5:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hull_count = value;
  endtask

  // random item; queries only when every scanned entry has been stored
  task automatic push_random_item();
    int         need;
    int         gap;
    int         src;
    logic [4:0] slot;
    need = (hull_count > NumVerts) ? NumVerts : int'(hull_count);
    if (need == 0) begin
      need = 1;                   // a count of zero still returns entry 0
    end
    gap = -1;
    for (int i = need - 1; i >= 0; i--) begin
      if (!hull_written[i]) begin
        gap = i;
      end
    end
    if (gap >= 0) begin
      push_item(OP_STORE, 5'(gap), pick_float(), pick_float(), pick_float(),
                $urandom, $urandom, $urandom, 1'b0, '0, '0);
    end else if ($urandom_range(0, 2) == 0) begin
      slot = 5'($urandom_range(0, NumVerts - 1));
      src  = $urandom_range(0, NumVerts - 1);
      if (hull_written[src] && $urandom_range(0, 3) == 0) begin
        // duplicate vertex: the lower index must win the tie
        push_item(OP_STORE, slot, hull_x[src], hull_y[src], hull_z[src],
                  $urandom, $urandom, $urandom, 1'b0, '0, '0);
      end else begin
        push_item(OP_STORE, slot, pick_float(), pick_float(), pick_float(),
                  $urandom, $urandom, $urandom, 1'b0, '0, '0);
      end
    end else begin
      push_item(OP_QUERY, 5'($urandom), $urandom, $urandom, $urandom,
                pick_float(), pick_float(), pick_float(), 1'b0, '0, '0);
    end
  endtask

  //----------------------------------------------------------------------------
  // result side: random stalls, compare against the oldest expectation
  //----------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    support_t want;
    support_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.idx  = m_axis_tdata[4:0];
      got.x    = m_axis_tdata[36:5];
      got.y    = m_axis_tdata[68:37];
      got.z    = m_axis_tdata[100:69];
      got.proj = m_axis_tdata[132:101];
      if (pending_supports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected support result idx=%0d proj=%h", got.idx, got.proj);
        end
      end else begin
        want = pending_supports.pop_front();
        if (got.idx !== want.idx || got.x !== want.x || got.y !== want.y ||
            got.z !== want.z || got.proj !== want.proj) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("support mismatch: expected idx=%0d x=%h y=%h z=%h proj=%h",
                     want.idx, want.x, want.y, want.z, want.proj);
            $display("                  actual   idx=%0d x=%h y=%h z=%h proj=%h",
                     got.idx, got.x, got.y, got.z, got.proj);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("convex_hull_support_argmax_unit_test NOT OK");
      $finish;
    end
  end

  //----------------------------------------------------------------------------
  // main sequence
  //----------------------------------------------------------------------------
  initial begin
    stim_row_t   rows [$];
    logic [5:0]  counts [NumPhases];
    for (int i = 0; i < NumVerts; i++) begin
      hull_x[i] = '0;
      hull_y[i] = '0;
      hull_z[i] = '0;
      hull_written[i] = 1'b0;
    end
    hull_count = 6'd1;
    counts = '{6'd32, 6'd0, 6'd63, 6'd33, 6'd1, 6'd7, 6'd32, 6'd20, 6'd2, 6'd32};

    // directed rows, run at the reset count of one vertex
    rows.push_back('{OP_STORE, 5'd0, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000,
                     '0, '0, '0, 1'b0, '0, '0});
    // (1,2,3).(1,1,1) = 6
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h3F80_0000, 32'h3F80_0000,
                     32'h3F80_0000, 1'b1, 5'd0, 32'h40C0_0000});
    // NaN direction: nothing wins
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h7FC0_0000, '0, '0,
                     1'b1, 5'd0, FpNegInf});
    rows.push_back('{OP_QUERY, 5'd31, '1, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 1'b1, 5'd0, FpNegInf});
    rows.push_back('{OP_STORE, 5'd0, 32'h7F80_0000, 32'h0000_0000, 32'h0000_0000,
                     '0, '0, '0, 1'b0, '0, '0});
    // projection of minus infinity never beats the starting value
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'hBF80_0000, '0, '0,
                     1'b1, 5'd0, FpNegInf});
    // infinity times zero gives NaN
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h3F80_0000, 32'h7F80_0000, '0,
                     1'b1, 5'd0, FpNegInf});
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h3F80_0000, '0, '0,
                     1'b1, 5'd0, 32'h7F80_0000});
    rows.push_back('{OP_STORE, 5'd31, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                     '0, '0, '0, 1'b0, '0, '0});
    rows.push_back('{OP_STORE, 5'd1, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                     '0, '0, '0, 1'b0, '0, '0});
    rows.push_back('{OP_STORE, 5'd0, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
                     '0, '0, '0, 1'b0, '0, '0});
    // overflow, subnormal products, signed zeros: predictor only
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
                     32'h7F7F_FFFF, 1'b0, '0, '0});
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h0000_0001, 32'h8000_0001,
                     32'h3F00_0000, 1'b0, '0, '0});
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h8000_0000, 32'h0000_0000,
                     32'h8000_0000, 1'b0, '0, '0});
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h3400_0000, 32'h3400_0000,
                     32'h7F80_0000, 1'b0, '0, '0});
    rows.push_back('{OP_STORE, 5'd0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
                     '0, '0, '0, 1'b0, '0, '0});
    rows.push_back('{OP_QUERY, 5'd0, '0, '0, '0, 32'h3F80_0001, 32'h3380_0000,
                     32'hB380_0000, 1'b0, '0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      push_item(rows[i].op, rows[i].idx, rows[i].vx, rows[i].vy, rows[i].vz,
                rows[i].dx, rows[i].dy, rows[i].dz, rows[i].has_exp,
                rows[i].exp_idx, rows[i].exp_proj);
    end

    // random phases, each at its own vertex count, written while idle
    for (int p = 0; p < NumPhases; p++) begin
      drain_queries();
      write_count(counts[p]);
      quiet = (p >= NumPhases - 2);
      for (int n = 0; n < PhaseItems; n++) begin
        push_random_item();
        if (p == 3 && n == PhaseItems / 2) begin
          drain_queries();        // sender holds off until all results are in
        end
      end
    end

    drain_queries();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_supports.size() == 0) begin
      $display("convex_hull_support_argmax_unit_test OK");
    end else begin
      $display("convex_hull_support_argmax_unit_test NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/chsa_pkg.sv
rtl/core/chsa_fpu.sv
rtl/core/convex_hull_support_argmax_unit.sv
rtl/core/chsa_checker.sv
tb/convex_hull_support_argmax_unit_test.sv
